>>> rtl/iol_pkg.sv
// Shared constants, request codes and beat types for the indexed ordered list.
`default_nettype none

package iol_pkg;

  // Slot count and the longest read-all stream
  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DATA_W = 32;

  // Request codes
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_ERASE  = 3'd1;
  localparam logic [2:0] REQ_FIND   = 3'd2;
  localparam logic [2:0] REQ_READ   = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  // Operation applied to every cell in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ERASE,
    CELL_ROTATE
  } cell_op_t;

  // Broadcast control from the sequencer to the cell row
  typedef struct packed {
    cell_op_t                 op;
    logic [CNT_W-1:0]         pos;
    logic [CNT_W-1:0]         count;
    logic [CNT_W-1:0]         span;
    logic signed [DATA_W-1:0] data;
  } cell_ctl_t;

  // Request beat
  typedef struct packed {
    logic [2:0]         req_type;
    logic [4:0]         position_in;
    logic signed [31:0] data_in;
  } req_t;

  // Result beat
  typedef struct packed {
    logic               ok;
    logic [3:0]         position_out;
    logic signed [31:0] data_out;
    logic [4:0]         count;
    logic               last;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/iol_cell.sv
// One slot of the list: holds a value, shifts with its neighbors, matches a key.
`default_nettype none

module iol_cell (
  input  wire logic                              clk,
  input  wire logic [iol_pkg::IDX_W-1:0]         idx,
  input  wire iol_pkg::cell_ctl_t                ctl,
  input  wire logic signed [iol_pkg::DATA_W-1:0] left,
  input  wire logic signed [iol_pkg::DATA_W-1:0] right,
  input  wire logic signed [iol_pkg::DATA_W-1:0] head,
  input  wire logic                              hit_in,
  output logic signed [iol_pkg::DATA_W-1:0]      slot,
  output logic                                   hit_out,
  output logic                                   first
);

  logic signed [iol_pkg::DATA_W-1:0] slot_next;
  logic [iol_pkg::CNT_W-1:0]         pos_here;
  logic [iol_pkg::CNT_W-1:0]         pos_after;
  logic                              match;

  assign pos_here  = iol_pkg::CNT_W'(idx);
  assign pos_after = pos_here + iol_pkg::CNT_W'(1);

  // Pick the next slot value from the broadcast operation
  always_comb begin
    slot_next = slot;
    case (ctl.op)
      iol_pkg::CELL_INSERT: begin
        if (pos_here == ctl.pos) begin
          slot_next = ctl.data;
        end else if (pos_here > ctl.pos && pos_here <= ctl.count) begin
          slot_next = left;
        end
      end
      iol_pkg::CELL_ERASE: begin
        if (pos_here >= ctl.pos && pos_after < ctl.count) begin
          slot_next = right;
        end
      end
      iol_pkg::CELL_ROTATE: begin
        if (pos_after < ctl.span) begin
          slot_next = right;
        end else if (pos_after == ctl.span) begin
          slot_next = head;
        end
      end
      default: begin
        slot_next = slot;
      end
    endcase
  end

  // Hold the slot value
  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

  // Pass the hit chain along; flag the first live match
  assign match   = (pos_here < ctl.count) && (slot == ctl.data);
  assign hit_out = hit_in | match;
  assign first   = match & ~hit_in;

endmodule

`default_nettype wire

>>> rtl/indexed_ordered_list.sv
// Top level of the indexed ordered list: request decode, cell row, result register.
//
// Bounded ordered list of signed 32-bit values in a row of 16 slot cells.
// Insert, erase, find and clear keep busy low: the single result beat
// appears with strobe in the cycle after start. Every cell shifts or compares
// in the same cycle, so inserts and erases move the whole tail at once and
// find resolves through a hit chain across the row.
// Read-all streams one entry per cycle by rotating the used cells past cell 0;
// it raises busy only for a stream of two or more entries, so an empty or
// one-entry list never raises busy.
// The rotation brings the list back to its original order by the last beat.
// Result beats cannot be stalled: take each one in the cycle strobe is high.
`default_nettype none

module indexed_ordered_list (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire iol_pkg::req_t req,
  output logic               strobe,
  output iol_pkg::rsp_t      rsp
);

  localparam int N = iol_pkg::CAPACITY;

  logic [iol_pkg::CNT_W-1:0]         count;
  logic [iol_pkg::CNT_W-1:0]         count_next;
  logic                              streaming;
  logic [iol_pkg::CNT_W-1:0]         span;
  logic [iol_pkg::IDX_W-1:0]         rd_idx;
  logic                              accept;
  logic [iol_pkg::CNT_W-1:0]         pos;
  logic [iol_pkg::CNT_W-1:0]         read_n;
  logic                              ins_ok;
  logic                              era_ok;
  logic                              found;
  logic [iol_pkg::IDX_W-1:0]         found_idx;
  logic                              stream_end;
  iol_pkg::cell_ctl_t                ctl;
  iol_pkg::rsp_t                     rsp_next;
  logic signed [iol_pkg::DATA_W-1:0] slot  [N];
  logic signed [iol_pkg::DATA_W-1:0] left  [N];
  logic signed [iol_pkg::DATA_W-1:0] right [N];
  logic                              hit   [N+1];
  logic                              first [N];

  assign busy   = streaming;
  assign accept = start & ~streaming;
  assign pos    = iol_pkg::CNT_W'(req.position_in);

  // Check indexes and clip the read-all length
  assign ins_ok = (pos <= count) && (count < iol_pkg::CNT_W'(N));
  assign era_ok = pos < count;
  assign read_n = (count > iol_pkg::CNT_W'(iol_pkg::MAX_RESULTS)) ?
                  iol_pkg::CNT_W'(iol_pkg::MAX_RESULTS) : count;
  assign stream_end = (iol_pkg::CNT_W'(rd_idx) + iol_pkg::CNT_W'(1)) == span;

  // Build the broadcast control for the row
  always_comb begin
    ctl.op    = iol_pkg::CELL_HOLD;
    ctl.pos   = pos;
    ctl.count = count;
    ctl.span  = streaming ? span : read_n;
    ctl.data  = req.data_in;
    if (streaming) begin
      ctl.op = iol_pkg::CELL_ROTATE;
    end else if (accept) begin
      unique case (req.req_type)
        iol_pkg::REQ_INSERT: ctl.op = ins_ok ? iol_pkg::CELL_INSERT : iol_pkg::CELL_HOLD;
        iol_pkg::REQ_ERASE:  ctl.op = era_ok ? iol_pkg::CELL_ERASE : iol_pkg::CELL_HOLD;
        iol_pkg::REQ_READ: begin
          ctl.op = (read_n != '0) ? iol_pkg::CELL_ROTATE : iol_pkg::CELL_HOLD;
        end
        default:             ctl.op = iol_pkg::CELL_HOLD;
      endcase
    end
  end

  // Wire up the cell row
  assign hit[0] = 1'b0;
  for (genvar g = 0; g < N; g++) begin : g_cell
    assign left[g]  = (g == 0) ? req.data_in : slot[(g == 0) ? 0 : g - 1];
    assign right[g] = (g == N - 1) ? slot[g] : slot[(g == N - 1) ? g : g + 1];

    iol_cell u_cell (
      .clk     (clk),
      .idx     (iol_pkg::IDX_W'(g)),
      .ctl     (ctl),
      .left    (left[g]),
      .right   (right[g]),
      .head    (slot[0]),
      .hit_in  (hit[g]),
      .slot    (slot[g]),
      .hit_out (hit[g+1]),
      .first   (first[g])
    );
  end

  // Encode the position of the first match
  assign found = hit[N];
  always_comb begin
    found_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) begin
        found_idx = found_idx | iol_pkg::IDX_W'(i);
      end
    end
  end

  // Form the next count and result beat
  always_comb begin
    count_next            = count;
    rsp_next.ok           = 1'b0;
    rsp_next.position_out = '0;
    rsp_next.data_out     = '0;
    rsp_next.last         = 1'b1;
    if (streaming) begin
      rsp_next.ok           = 1'b1;
      rsp_next.position_out = 4'(rd_idx);
      rsp_next.data_out     = slot[0];
      rsp_next.last         = stream_end;
    end else if (accept) begin
      unique case (req.req_type)
        iol_pkg::REQ_INSERT: begin
          rsp_next.ok = ins_ok;
          if (ins_ok) begin
            count_next = count + iol_pkg::CNT_W'(1);
          end
        end
        iol_pkg::REQ_ERASE: begin
          rsp_next.ok = era_ok;
          if (era_ok) begin
            count_next = count - iol_pkg::CNT_W'(1);
          end
        end
        iol_pkg::REQ_FIND: begin
          rsp_next.ok = found;
          if (found) begin
            rsp_next.position_out = 4'(found_idx);
            rsp_next.data_out     = req.data_in;
          end
        end
        iol_pkg::REQ_READ: begin
          rsp_next.ok   = read_n != '0;
          rsp_next.last = read_n <= iol_pkg::CNT_W'(1);
          if (read_n != '0) begin
            rsp_next.data_out = slot[0];
          end
        end
        iol_pkg::REQ_CLEAR: begin
          rsp_next.ok = 1'b1;
          count_next  = '0;
        end
        default: begin
          rsp_next.ok = 1'b0;
        end
      endcase
    end
    rsp_next.count = 5'(count_next);
  end

  // Hold count, stream state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      streaming <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      count  <= count_next;
      strobe <= accept | streaming;
      if (streaming) begin
        if (stream_end) begin
          streaming <= 1'b0;
        end
      end else if (accept && req.req_type == iol_pkg::REQ_READ) begin
        streaming <= read_n > iol_pkg::CNT_W'(1);
      end
    end
  end

  // Advance the read index; capture the stream length
  always_ff @(posedge clk) begin
    if (streaming) begin
      rd_idx <= rd_idx + iol_pkg::IDX_W'(1);
    end else if (accept) begin
      rd_idx <= iol_pkg::IDX_W'(1);
      span   <= read_n;
    end
    rsp <= rsp_next;
  end

endmodule

`default_nettype wire

>>> rtl/iol_checker.sv
// Port-level checks for the indexed ordered list, bound to the top level.
`default_nettype none

module iol_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire iol_pkg::req_t req,
  input wire logic          strobe,
  input wire iol_pkg::rsp_t rsp
);

  // Every accepted request gives a beat in the next cycle
  a_accept_beat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> strobe)
    else $error("no result beat after accepted request");

  // A stream in progress produces a beat every cycle
  a_busy_beat: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("stream stalled while busy");

  // A beat that is not last is followed by another beat
  a_stream_cont: assert property (@(posedge clk) disable iff (rst)
    (strobe && !rsp.last) |=> (strobe && busy == $past(busy) || strobe))
    else $error("stream ended without a last beat");

  // Failed requests give a single beat
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !rsp.ok) |-> rsp.last)
    else $error("failed request beat not marked last");

  // Reported count never exceeds the slot count
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (rsp.count <= 5'(iol_pkg::CAPACITY)))
    else $error("count beyond capacity");

endmodule

bind indexed_ordered_list iol_checker u_iol_checker (.*);

`default_nettype wire
